[sv/mis_pkg.sv]
// ----------------------------------------------------------------------------
// mis_pkg: shared types and codes for the magazine index sequencer
// Holds the request and result structs, the action, mode, sub-step and drive
// codes, and the default slot limit.
// ----------------------------------------------------------------------------
`default_nettype none

package mis_pkg;

  // Widths of the stream buses
  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 16;

  // Default number of slots in the magazine
  localparam int SLOT_COUNT_DEF = 4;
  // Largest value the slot counter holds
  localparam logic [2:0] SLOT_MAX = 3'd7;

  // Action codes
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_NEXT_LOAD = 3'd2;
  localparam logic [2:0] ACT_NEXT_FIRE = 3'd3;
  localparam logic [2:0] ACT_UNKNOWN   = 3'd4;

  // Motor drive codes
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_UP   = 2'd1;
  localparam logic [1:0] DRV_DOWN = 2'd2;

  // Mode codes
  localparam logic [2:0] M_FIRE    = 3'd0;
  localparam logic [2:0] M_LOAD    = 3'd1;
  localparam logic [2:0] M_TO_FIRE = 3'd2;
  localparam logic [2:0] M_TO_LOAD = 3'd3;
  localparam logic [2:0] M_UNKNOWN = 3'd4;

  // Sub-step codes
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOAD_OFF = 3'd1;
  localparam logic [2:0] S_LOAD_ON  = 3'd2;
  localparam logic [2:0] S_BOTTOM   = 3'd3;
  localparam logic [2:0] S_FIRE_OFF = 3'd4;
  localparam logic [2:0] S_FIRE_ON  = 3'd5;
  localparam logic [2:0] S_TOP      = 3'd6;

  // One request: an action and a tick of switch readings
  typedef struct packed {
    logic [2:0] action;
    logic       at_top_limit;
    logic       at_bottom_limit;
    logic       loading_switch_on;
    logic       firing_switch_on;
    logic       lower_index_switch;
    logic       upper_index_switch;
    logic       top_end_switch;
    logic       bottom_end_switch;
    logic       kicker_stowed;
  } item_t;

  // One result: sequencer state after a request
  typedef struct packed {
    logic [1:0] motor_drive;
    logic [2:0] mode;
    logic [2:0] sub_step;
    logic [2:0] slot_position;
  } result_t;

endpackage

`default_nettype wire

[sv/magazine_index_sequencer_top.sv]
// ----------------------------------------------------------------------------
// magazine_index_sequencer_top: up/down indexing magazine sequencer
// Usage:
//   Requests arrive on the slave stream (s_tvalid/s_tready), the action code
//   on s_tuser and the switch readings on s_tdata. Each request gives exactly
//   one result on the master stream (m_tvalid/m_tready): held motor drive,
//   mode, sub-step and slot position after that request.
//   From acceptance to m_tvalid a request goes into the request register,
//   then through the state update into the result register once that has
//   room. Requests are taken at one per cycle while the receiver does not
//   stall; the state update is combinational logic, so each request sees
//   the state left by the one before it.
//   When the receiver stalls, the result register holds its result and the
//   request register fills; s_tready drops once both are full and rises in
//   the cycle the result is taken.
//   Reset clears both stream registers and sets the state to position
//   unknown, sub-step idle, slot zero and motor stopped.
//   SLOT_COUNT sets the slot limit, capped at seven.
// ----------------------------------------------------------------------------
`default_nettype none

module magazine_index_sequencer_top #(
  parameter int SLOT_COUNT = mis_pkg::SLOT_COUNT_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // s_tdata: at_top_limit, at_bottom_limit, loading_switch_on, firing_switch_on,
  //          lower_index_switch, upper_index_switch, top_end_switch,
  //          bottom_end_switch, kicker_stowed, zero fill
  input  wire  [mis_pkg::S_DATA_W-1:0]  s_tdata,
  // s_tuser: action
  input  wire  [mis_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // m_tdata: motor_drive, mode, sub_step, slot_position, zero fill
  output logic [mis_pkg::M_DATA_W-1:0]  m_tdata
);
  import mis_pkg::*;

  item_t   item;
  result_t result_next;
  logic    item_valid;
  logic    out_free;
  logic    advance;

  // Move a held request into the result register when there is room
  assign advance = item_valid && out_free;

  mis_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mis_core #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item),
    .result_next (result_next)
  );

  mis_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .result_next (result_next),
    .out_free    (out_free),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

`default_nettype wire

[sv/mis_in_stage.sv]
// ----------------------------------------------------------------------------
// mis_in_stage: input request register
// Unpacks the slave stream into a request and holds it until the core takes
// it; takes a new request in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module mis_in_stage (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // s_tdata: at_top_limit, at_bottom_limit, loading_switch_on, firing_switch_on,
  //          lower_index_switch, upper_index_switch, top_end_switch,
  //          bottom_end_switch, kicker_stowed, zero fill
  input  wire  [mis_pkg::S_DATA_W-1:0]  s_tdata,
  // s_tuser: action
  input  wire  [mis_pkg::S_USER_W-1:0]  s_tuser,
  input  wire                           advance,
  output logic                          item_valid,
  output mis_pkg::item_t                item
);
  import mis_pkg::*;

  // Free when empty or when the held request moves on this cycle
  assign s_tready = !item_valid || advance;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.action             <= s_tuser[2:0];
      item.at_top_limit       <= s_tdata[0];
      item.at_bottom_limit    <= s_tdata[1];
      item.loading_switch_on  <= s_tdata[2];
      item.firing_switch_on   <= s_tdata[3];
      item.lower_index_switch <= s_tdata[4];
      item.upper_index_switch <= s_tdata[5];
      item.top_end_switch     <= s_tdata[6];
      item.bottom_end_switch  <= s_tdata[7];
      item.kicker_stowed      <= s_tdata[8];
    end
  end

endmodule

`default_nettype wire

[sv/mis_core.sv]
// ----------------------------------------------------------------------------
// mis_core: indexing state machine
// Keeps mode, sub-step, slot count and held drive, and works out their next
// values for one request in combinational logic.
// ----------------------------------------------------------------------------
`default_nettype none

module mis_core #(
  parameter int SLOT_COUNT = mis_pkg::SLOT_COUNT_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                advance,
  input  mis_pkg::item_t     item,
  output mis_pkg::result_t   result_next
);
  import mis_pkg::*;

  // Slot limit, capped at what the counter holds
  localparam logic [2:0] SlotLimit =
    (SLOT_COUNT > 7) ? SLOT_MAX : 3'(SLOT_COUNT);

  logic [2:0] mode;
  logic [2:0] sub_step;
  logic [2:0] slot_count;
  logic [1:0] drive;

  logic [2:0] mode_next;
  logic [2:0] sub_step_next;
  logic [2:0] slot_count_next;
  logic [1:0] drive_next;
  logic [2:0] slot_bumped;

  // Saturating slot increment
  assign slot_bumped = (slot_count == SLOT_MAX) ? slot_count : slot_count + 3'd1;

  // Next-state logic
  always_comb begin
    mode_next       = mode;
    sub_step_next   = sub_step;
    slot_count_next = slot_count;
    drive_next      = drive;
    case (item.action)
      ACT_TICK: begin
        case (mode)
          M_FIRE, M_LOAD: begin
            sub_step_next = S_IDLE;
          end
          M_TO_LOAD: begin
            case (sub_step)
              S_IDLE: begin
                // Start a loading seek
                if (slot_count == 3'd0) begin
                  if (item.at_bottom_limit) begin
                    if (item.loading_switch_on) begin
                      drive_next      = DRV_STOP;
                      slot_count_next = 3'd1;
                      mode_next       = M_LOAD;
                    end else begin
                      sub_step_next = S_LOAD_ON;
                      drive_next    = DRV_UP;
                    end
                  end else begin
                    sub_step_next = S_BOTTOM;
                    drive_next    = DRV_DOWN;
                  end
                end else if (slot_count < SlotLimit) begin
                  sub_step_next = item.lower_index_switch ? S_LOAD_OFF : S_LOAD_ON;
                  drive_next    = DRV_UP;
                end
              end
              S_LOAD_OFF: begin
                if (!item.lower_index_switch) begin
                  sub_step_next = S_LOAD_ON;
                end
                if (item.kicker_stowed) begin
                  drive_next = DRV_UP;
                end
              end
              S_LOAD_ON: begin
                if (item.lower_index_switch) begin
                  drive_next      = DRV_STOP;
                  sub_step_next   = S_IDLE;
                  mode_next       = M_LOAD;
                  slot_count_next = slot_bumped;
                end else if (item.kicker_stowed) begin
                  drive_next = DRV_UP;
                end
              end
              S_BOTTOM: begin
                if (item.bottom_end_switch) begin
                  drive_next    = DRV_STOP;
                  sub_step_next = S_LOAD_ON;
                end
              end
              default: begin
                drive_next = DRV_STOP;
              end
            endcase
          end
          M_TO_FIRE: begin
            case (sub_step)
              S_IDLE: begin
                // Start a firing seek
                if (slot_count == 3'd0) begin
                  if (item.at_top_limit) begin
                    if (item.firing_switch_on) begin
                      drive_next      = DRV_STOP;
                      slot_count_next = 3'd1;
                      mode_next       = M_FIRE;
                    end else begin
                      sub_step_next = S_FIRE_ON;
                      drive_next    = DRV_DOWN;
                    end
                  end else begin
                    sub_step_next = S_TOP;
                    drive_next    = DRV_UP;
                  end
                end else if (slot_count < SlotLimit) begin
                  sub_step_next = item.upper_index_switch ? S_FIRE_OFF : S_FIRE_ON;
                  if (item.kicker_stowed) begin
                    drive_next = DRV_DOWN;
                  end
                end
              end
              S_FIRE_OFF: begin
                if (!item.upper_index_switch) begin
                  sub_step_next = S_FIRE_ON;
                end
                if (item.kicker_stowed) begin
                  drive_next = DRV_DOWN;
                end
              end
              S_FIRE_ON: begin
                if (item.upper_index_switch) begin
                  drive_next      = DRV_STOP;
                  sub_step_next   = S_IDLE;
                  mode_next       = M_FIRE;
                  slot_count_next = slot_bumped;
                end else if (item.kicker_stowed) begin
                  drive_next = DRV_DOWN;
                end
              end
              S_TOP: begin
                if (item.top_end_switch) begin
                  drive_next    = DRV_STOP;
                  sub_step_next = S_FIRE_ON;
                end
              end
              default: begin
                drive_next = DRV_STOP;
              end
            endcase
          end
          M_UNKNOWN: begin
            // Forget the position and start a firing seek from slot zero
            slot_count_next = 3'd0;
            mode_next       = M_TO_FIRE;
            if (item.at_top_limit) begin
              if (item.firing_switch_on) begin
                drive_next      = DRV_STOP;
                slot_count_next = 3'd1;
                mode_next       = M_FIRE;
              end else begin
                sub_step_next = S_FIRE_ON;
                drive_next    = DRV_DOWN;
              end
            end else begin
              sub_step_next = S_TOP;
              drive_next    = DRV_UP;
            end
          end
          default: begin
            mode_next = mode;
          end
        endcase
      end
      ACT_START: begin
        mode_next       = item.at_top_limit ? M_TO_FIRE : M_TO_LOAD;
        slot_count_next = 3'd0;
        sub_step_next   = S_IDLE;
      end
      ACT_NEXT_LOAD: begin
        mode_next     = M_TO_LOAD;
        sub_step_next = S_IDLE;
      end
      ACT_NEXT_FIRE: begin
        mode_next     = M_TO_FIRE;
        sub_step_next = S_IDLE;
      end
      ACT_UNKNOWN: begin
        mode_next = M_UNKNOWN;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // Hand the new state to the result register
  assign result_next.motor_drive   = drive_next;
  assign result_next.mode          = mode_next;
  assign result_next.sub_step      = sub_step_next;
  assign result_next.slot_position = slot_count_next;

  // Update state once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_UNKNOWN;
      sub_step   <= S_IDLE;
      slot_count <= 3'd0;
      drive      <= DRV_STOP;
    end else if (advance) begin
      mode       <= mode_next;
      sub_step   <= sub_step_next;
      slot_count <= slot_count_next;
      drive      <= drive_next;
    end
  end

endmodule

`default_nettype wire

[sv/mis_out_stage.sv]
// ----------------------------------------------------------------------------
// mis_out_stage: result register
// Holds one result on the master stream until the receiver takes it, and
// reports whether a new result can be loaded this cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mis_out_stage (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           load,
  input  mis_pkg::result_t              result_next,
  output logic                          out_free,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // m_tdata: motor_drive, mode, sub_step, slot_position, zero fill
  output logic [mis_pkg::M_DATA_W-1:0]  m_tdata
);
  import mis_pkg::*;

  result_t result;

  // Free when empty or when the held result is taken this cycle
  assign out_free = !m_tvalid || m_tready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  // Pack the bus, first field lowest
  assign m_tdata = {5'd0, result.slot_position, result.sub_step, result.mode,
                    result.motor_drive};

endmodule

`default_nettype wire
